/* rtl/core/ghi_pkg.sv */
// Shared types and constants for the gyro heading integrator.
`default_nettype none

package ghi_pkg;

    localparam int FUNC_W  = 2;
    localparam int RATE_W  = 16;
    localparam int ANGLE_W = 23;
    localparam int STEP_W  = 18;
    localparam int BIAS_W  = 24;
    localparam int DELTA_W = 17;
    localparam int CALC_W  = 25;

    localparam logic [FUNC_W-1:0] FUNC_CAL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GPS  = 2'd2;

    localparam logic [ANGLE_W-1:0] FULL_TURN  = 23'd5898240;
    localparam logic [ANGLE_W-1:0] HALF_TURN  = 23'd2949120;
    localparam int                 MAX_DELTA  = 49152;
    localparam int                 MAX_Q      = MAX_DELTA / 10;
    localparam logic [STEP_W-1:0]  STEP_RESET = 18'd1638;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [RATE_W-1:0] gyro_rate;
        logic [ANGLE_W-1:0]       gps_course;
    } t_in_beat;

    typedef struct packed {
        logic [ANGLE_W-1:0] heading;
        logic               ready_res;
    } t_out_beat;

    typedef struct packed {
        logic              load;
        logic [FUNC_W-1:0] func;
        logic              cal_done;
    } t_head_ctl;

endpackage

`default_nettype wire

/* rtl/core/ghi_cal.sv */
// Calibration accumulator: sums samples and latches the bias sum.
`default_nettype none

module ghi_cal #(
    parameter int BIAS_SAMPLES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic signed [ghi_pkg::RATE_W-1:0] i_rate,
    output logic signed [ghi_pkg::BIAS_W-1:0] o_bias_sum,
    output logic                              o_done
);
    import ghi_pkg::*;

    localparam int CNT_W = $clog2(BIAS_SAMPLES);

    logic [CNT_W-1:0]         r_cal_count;
    logic [CNT_W:0]           n_cal_count;
    logic signed [BIAS_W-1:0] r_cal_sum;
    logic signed [BIAS_W-1:0] n_cal_sum;
    logic signed [BIAS_W-1:0] r_bias_sum;

    assign n_cal_count = {1'b0, r_cal_count} + (CNT_W+1)'(1);
    assign n_cal_sum   = r_cal_sum + {{(BIAS_W-RATE_W){i_rate[RATE_W-1]}}, i_rate};
    assign o_done      = i_en && (n_cal_count == (CNT_W+1)'(BIAS_SAMPLES));
    assign o_bias_sum  = r_bias_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_count <= '0;
            r_cal_sum   <= '0;
            r_bias_sum  <= '0;
        end else if (i_en) begin
            if (o_done) begin
                r_bias_sum  <= n_cal_sum;
                r_cal_sum   <= '0;
                r_cal_count <= '0;
            end else begin
                r_cal_sum   <= n_cal_sum;
                r_cal_count <= n_cal_count[CNT_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ghi_delta.sv */
// Gyro delta: de-bias, truncate to 10 LSB steps by reciprocal multiply, clamp.
`default_nettype none

module ghi_delta #(
    parameter int BIAS_SAMPLES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic signed [ghi_pkg::RATE_W-1:0]  i_rate,
    input  logic signed [ghi_pkg::BIAS_W-1:0]  i_bias,
    output logic signed [ghi_pkg::DELTA_W-1:0] o_delta
);
    import ghi_pkg::*;

    localparam int NUM_W   = CALC_W + 1;
    localparam int DIV     = 10 * BIAS_SAMPLES;
    localparam int DIV_LOG = $clog2(DIV);
    localparam int SHIFT   = CALC_W + DIV_LOG;
    localparam int RECIP_W = CALC_W + 2;
    localparam int PROD_W  = SHIFT + CALC_W;
    localparam int Q_W     = CALC_W + 1 - DIV_LOG;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic signed [NUM_W-1:0] rate_ext;
    logic signed [NUM_W-1:0] bias_ext;
    logic signed [NUM_W-1:0] num;
    logic                    neg;
    logic [CALC_W-1:0]       mag;
    logic [PROD_W-1:0]       prod;
    logic                    r_neg;
    logic [Q_W-1:0]          r_q;
    logic [DELTA_W-1:0]      mag_d;

    assign rate_ext = NUM_W'(i_rate);
    assign bias_ext = NUM_W'(i_bias);
    assign num      = rate_ext * $signed(NUM_W'(BIAS_SAMPLES)) - bias_ext;
    assign neg      = num[NUM_W-1];
    assign mag      = neg ? CALC_W'(-num) : CALC_W'(num);
    assign prod     = PROD_W'(mag) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= neg;
            r_q   <= prod[SHIFT +: Q_W];
        end
    end

    assign mag_d   = (r_q > Q_W'(MAX_Q)) ? DELTA_W'(MAX_DELTA)
                                         : DELTA_W'(r_q) * DELTA_W'(10);
    assign o_delta = r_neg ? -$signed(mag_d) : $signed(mag_d);

endmodule

`default_nettype wire

/* rtl/core/ghi_heading.sv */
// Heading register: gyro integration, GPS nudge, wrap and ready flag.
`default_nettype none

module ghi_heading (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ghi_pkg::t_head_ctl                 i_ctl,
    input  logic signed [ghi_pkg::DELTA_W-1:0] i_delta,
    input  logic [ghi_pkg::ANGLE_W-1:0]        i_course,
    input  logic [ghi_pkg::STEP_W-1:0]         i_step,
    output logic [ghi_pkg::ANGLE_W-1:0]        o_heading,
    output logic                               o_ready
);
    import ghi_pkg::*;

    localparam logic signed [CALC_W-1:0] FULL_S = CALC_W'(FULL_TURN);
    localparam logic signed [CALC_W-1:0] HALF_S = CALC_W'(HALF_TURN);

    logic [ANGLE_W-1:0]       r_heading;
    logic [ANGLE_W-1:0]       n_heading;
    logic                     r_ready;
    logic                     n_ready;
    logic signed [CALC_W-1:0] head_ext;
    logic signed [CALC_W-1:0] step_ext;
    logic signed [CALC_W-1:0] diff;
    logic signed [CALC_W-1:0] diff_w;
    logic signed [CALC_W-1:0] addend;
    logic signed [CALC_W-1:0] sum;
    logic [ANGLE_W-1:0]       wrap_head;

    assign head_ext = CALC_W'(r_heading);
    assign step_ext = CALC_W'(i_step);
    assign diff     = CALC_W'(i_course) - head_ext;

    // single wrap of the course difference; its sign picks the direction
    always_comb begin
        priority if (diff > HALF_S) begin
            diff_w = diff - FULL_S;
        end else if (diff < -HALF_S) begin
            diff_w = diff + FULL_S;
        end else begin
            diff_w = diff;
        end
    end

    always_comb begin
        addend = '0;
        unique case (i_ctl.func)
            FUNC_TICK: begin
                addend = CALC_W'(i_delta);
            end
            FUNC_GPS: begin
                priority if (diff_w > 0) begin
                    addend = step_ext;
                end else if (diff_w < 0) begin
                    addend = -step_ext;
                end else begin
                    addend = '0;
                end
            end
            default: begin
                addend = '0;
            end
        endcase
    end

    assign sum = head_ext + addend;

    always_comb begin
        priority if (sum >= FULL_S) begin
            wrap_head = ANGLE_W'(sum - FULL_S);
        end else if (sum < 0) begin
            wrap_head = ANGLE_W'(sum + FULL_S);
        end else begin
            wrap_head = ANGLE_W'(sum);
        end
    end

    always_comb begin
        n_heading = r_heading;
        n_ready   = r_ready;
        unique case (i_ctl.func)
            FUNC_CAL: begin
                if (i_ctl.cal_done) begin
                    n_heading = '0;
                    n_ready   = 1'b1;
                end
            end
            FUNC_TICK, FUNC_GPS: begin
                if (r_ready) begin
                    n_heading = wrap_head;
                end
            end
            default: begin
                n_heading = r_heading;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_ready   <= 1'b0;
        end else if (i_ctl.load) begin
            r_heading <= n_heading;
            r_ready   <= n_ready;
        end
    end

    assign o_heading = n_heading;
    assign o_ready   = n_ready;

endmodule

`default_nettype wire

/* rtl/core/gyro_heading_integrator_top.sv */
// Gyro heading integrator: top level with pipeline control and config register.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one beat per item:
// calibration sample, gyro tick or GPS course. Every item gives exactly one
// result beat on the output channel (o_out_valid / i_out_stall / o_out_data)
// carrying the heading after the item and the ready flag.
// Three register stages: input register, reciprocal-multiply register, result
// register; a beat passes through them in that order. One item per cycle
// sustained while the output is not stalled; the 25 x 27 bit reciprocal
// multiply sits between the first two stages.
// The config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the GPS
// correction step; ready is always high. Write it only while the block is idle.
// Reset (synchronous, active low) empties the pipeline, clears heading,
// calibration sums and ready, and sets the step to 1638.
// When the receiver stalls, the result beat holds; stages behind it keep
// filling bubbles and input stalls only once all stages are occupied.
`default_nettype none

module gyro_heading_integrator_top #(
    parameter int BIAS_SAMPLES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ghi_pkg::t_in_beat                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ghi_pkg::t_out_beat               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ghi_pkg::STEP_W-1:0]       i_cfg_data
);
    import ghi_pkg::*;

    logic                        r_s1_valid;
    t_in_beat                    r_s1;
    logic                        r_s2_valid;
    logic [FUNC_W-1:0]           r_s2_func;
    logic [ANGLE_W-1:0]          r_s2_course;
    logic                        r_s2_cal_done;
    logic                        r_out_valid;
    t_out_beat                   r_out;
    logic [STEP_W-1:0]           r_step;

    logic                        rdy_out;
    logic                        rdy_s2;
    logic                        rdy_s1;
    logic                        cal_en;
    logic                        cal_done;
    logic signed [BIAS_W-1:0]    bias_sum;
    logic signed [DELTA_W-1:0]   delta;
    t_head_ctl                   head_ctl;
    logic [ANGLE_W-1:0]          head_next;
    logic                        ready_next;

    assign rdy_out    = !r_out_valid || !i_out_stall;
    assign rdy_s2     = !r_s2_valid || rdy_out;
    assign rdy_s1     = !r_s1_valid || rdy_s2;
    assign o_in_stall = !rdy_s1;
    assign o_cfg_ready = 1'b1;

    assign cal_en = r_s1_valid && rdy_s2 && (r_s1.func == FUNC_CAL);

    ghi_cal #(
        .BIAS_SAMPLES (BIAS_SAMPLES)
    ) u_cal (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (cal_en),
        .i_rate     (r_s1.gyro_rate),
        .o_bias_sum (bias_sum),
        .o_done     (cal_done)
    );

    ghi_delta #(
        .BIAS_SAMPLES (BIAS_SAMPLES)
    ) u_delta (
        .i_clk   (i_clk),
        .i_load  (rdy_s2),
        .i_rate  (r_s1.gyro_rate),
        .i_bias  (bias_sum),
        .o_delta (delta)
    );

    assign head_ctl.load     = r_s2_valid && rdy_out;
    assign head_ctl.func     = r_s2_func;
    assign head_ctl.cal_done = r_s2_cal_done;

    ghi_heading u_heading (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (head_ctl),
        .i_delta   (delta),
        .i_course  (r_s2_course),
        .i_step    (r_step),
        .o_heading (head_next),
        .o_ready   (ready_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= STEP_RESET;
        end else begin
            if (rdy_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (rdy_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy_out) begin
                r_out_valid <= r_s2_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_step <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1 <= i_in_data;
        end
        if (rdy_s2) begin
            r_s2_func     <= r_s1.func;
            r_s2_course   <= r_s1.gps_course;
            r_s2_cal_done <= cal_done;
        end
        if (rdy_out && r_s2_valid) begin
            r_out.heading   <= head_next;
            r_out.ready_res <= ready_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/core/ghi_checker.sv */
// Port-level checks for the gyro heading integrator, bound to the top level.
`default_nettype none

module ghi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ghi_pkg::t_out_beat o_out_data
);
    import ghi_pkg::*;

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.heading < FULL_TURN))
        else $error("heading out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind gyro_heading_integrator_top ghi_checker u_ghi_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the gyro heading integrator.
`timescale 1ns / 100ps

module testbench;
    import ghi_pkg::*;

    localparam int              CAL_LEN     = 256;
    localparam int              CYCLE_LIMIT = 1_000_000;
    localparam int              MAX_REPORTS = 10;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam longint          TURN        = FULL_TURN;
    localparam longint          HALF        = HALF_TURN;
    localparam longint          ANGLE_SPAN  = 64'd1 << ANGLE_W;

    typedef struct {
        logic [FUNC_W-1:0] func;
        int                rate;
        int                course;
        bit                fixed;
        int                want_hdg;
        bit                want_rdy;
    } t_dir_row;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_beat           in_beat   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_beat          out_beat;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [STEP_W-1:0]  cfg_data  = '0;

    // predicted block state
    logic [ANGLE_W-1:0] est_heading;
    int                 est_bias;
    int                 est_cal_sum;
    int                 est_cal_cnt;
    bit                 est_ready;
    logic [STEP_W-1:0]  est_step;

    t_out_beat          heading_due_q[$];
    t_dir_row           dir_tbl[16];

    int cycles;
    int fail_cnt;
    int results_seen;
    int cal_rounds;
    int step_writes;
    int n_cal, n_tick, n_gps, n_spare;
    int tx_calm, rx_calm;
    int stall_left;
    int rx_gap;

    gyro_heading_integrator_top #(
        .BIAS_SAMPLES(CAL_LEN)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_beat),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     heading_due_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int spread(input int w);
        return int'($urandom_range(0, 2 * w)) - w;
    endfunction

    function automatic logic signed [RATE_W-1:0] sat_rate(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[RATE_W-1:0];
    endfunction

    // mostly short gaps, some long ones, with quiet stretches of none
    function automatic int pick_delay(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint wrap_turn(input longint a);
        if (a >= TURN) a -= TURN;
        if (a < 0) a += TURN;
        return a;
    endfunction

    function automatic t_out_beat advance_heading(input t_in_beat b);
        longint    rate;
        longint    acc;
        longint    q;
        longint    delta;
        longint    diff;
        t_out_beat r;
        rate = longint'(b.gyro_rate);
        acc  = longint'(est_heading);
        case (b.func)
            FUNC_CAL: begin
                n_cal++;
                est_cal_sum += int'(rate);
                if (est_cal_cnt + 1 >= CAL_LEN) begin
                    est_bias    = est_cal_sum;
                    est_cal_sum = 0;
                    est_cal_cnt = 0;
                    acc         = 0;
                    est_ready   = 1'b1;
                    cal_rounds++;
                end else begin
                    est_cal_cnt++;
                end
            end
            FUNC_TICK: begin
                n_tick++;
                if (est_ready) begin
                    q     = (rate * CAL_LEN - longint'(est_bias)) / (CAL_LEN * 10);
                    delta = q * 10;
                    if (delta > MAX_DELTA) delta = MAX_DELTA;
                    if (delta < -MAX_DELTA) delta = -MAX_DELTA;
                    acc = wrap_turn(acc + delta);
                end
            end
            FUNC_GPS: begin
                n_gps++;
                if (est_ready) begin
                    diff = longint'(b.gps_course) - acc;
                    if (diff > HALF) diff -= TURN;
                    if (diff < -HALF) diff += TURN;
                    if (diff > 0) acc = wrap_turn(acc + longint'(est_step));
                    else if (diff < 0) acc = wrap_turn(acc - longint'(est_step));
                end
            end
            default: n_spare++;
        endcase
        est_heading = acc[ANGLE_W-1:0];
        r.heading   = est_heading;
        r.ready_res = est_ready;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic send_beat(input t_in_beat b, input bit fixed, input t_out_beat want);
        int        gap;
        t_out_beat got;
        gap = pick_delay(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        got = advance_heading(b);
        heading_due_q.push_back(fixed ? want : got);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (heading_due_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        est_step = v;
        step_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(input int cal_pct, input int centre, output bit counted);
        t_in_beat b;
        int       r;
        int       m;
        longint   h;
        longint   c;
        int       mean;
        b.gyro_rate  = RATE_W'($urandom);
        b.gps_course = ANGLE_W'($urandom);
        h    = longint'(est_heading);
        mean = est_bias / CAL_LEN;
        r    = $urandom_range(0, 99);
        m    = $urandom_range(0, 99);
        if (r < cal_pct) begin
            b.func      = FUNC_CAL;
            b.gyro_rate = sat_rate(longint'(centre + spread(300)));
        end else if (r < cal_pct + 3) begin
            b.func = FUNC_SPARE;
        end else if ($urandom_range(0, 99) < 60) begin
            b.func = FUNC_TICK;
            if (m < 80) b.gyro_rate = sat_rate(longint'(mean + spread(6000)));
            else if (m < 90) b.gyro_rate = RATE_W'($urandom);
            else b.gyro_rate = sat_rate(longint'(mean + spread(12)));
        end else begin
            b.func = FUNC_GPS;
            if (m < 35) c = longint'($urandom_range(0, int'(TURN) - 1));
            else if (m < 55) c = h + spread(2 * int'(est_step) + 2);
            else if (m < 65) c = h;
            else if (m < 75) c = h + HALF;
            else if (m < 85) c = h - HALF;
            else c = longint'($urandom_range(int'(TURN), int'(ANGLE_SPAN) - 1));
            b.gps_course = c[ANGLE_W-1:0];
        end
        counted = (b.func != FUNC_SPARE);
        send_beat(b, 1'b0, '0);
    endtask

    task automatic run_phase(input bit recal, input int centre, input int n_items);
        int start;
        int done;
        bit counted;
        start = cal_rounds;
        done  = 0;
        while (recal ? (cal_rounds == start) : (done < n_items)) begin
            random_item(recal ? 70 : 3, centre, counted);
            if (counted) done++;
        end
    endtask

    // result side: random stall, check each beat taken
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (heading_due_q.size() == 0) begin
                    note_failure($sformatf("unexpected beat heading=%0d ready=%0b",
                                           out_beat.heading, out_beat.ready_res));
                end else if (out_beat !== heading_due_q[0]) begin
                    note_failure($sformatf(
                        "beat %0d: heading exp %0d got %0d, ready exp %0b got %0b",
                        results_seen, heading_due_q[0].heading,
                        out_beat.heading, heading_due_q[0].ready_res,
                        out_beat.ready_res));
                    void'(heading_due_q.pop_front());
                end else begin
                    void'(heading_due_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                rx_gap = pick_delay(rx_calm);
                out_stall <= (rx_gap > 0);
                if (rx_gap > 0) stall_left = rx_gap - 1;
            end
        end
    end

    initial begin
        t_in_beat          b;
        t_out_beat         want;
        logic [STEP_W-1:0] step_plan[6];
        int                centre;
        int                drain;

        est_heading = '0;
        est_bias    = 0;
        est_cal_sum = 0;
        est_cal_cnt = 0;
        est_ready   = 1'b0;
        est_step    = STEP_RESET;

        // first five rows precede the first calibration
        dir_tbl = '{
            '{FUNC_TICK,   32767,       0, 1'b1,     0, 1'b0},
            '{FUNC_TICK,  -32768, 5898239, 1'b1,     0, 1'b0},
            '{FUNC_GPS,        0, 5898239, 1'b1,     0, 1'b0},
            '{FUNC_GPS,        0,       0, 1'b1,     0, 1'b0},
            '{FUNC_SPARE,     -1, 8388607, 1'b1,     0, 1'b0},
            '{FUNC_TICK,   32767,       0, 1'b1, 49152, 1'b1},
            '{FUNC_TICK,  -32759,       0, 1'b0,     0, 1'b0},
            '{FUNC_TICK,  -32758,       0, 1'b0,     0, 1'b0},
            '{FUNC_GPS,        0,   49162, 1'b0,     0, 1'b0},
            '{FUNC_GPS,        0, 2998282, 1'b0,     0, 1'b0},
            '{FUNC_GPS,        0, 2999921, 1'b0,     0, 1'b0},
            '{FUNC_GPS,        0, 8388607, 1'b0,     0, 1'b0},
            '{FUNC_GPS,        0,       0, 1'b0,     0, 1'b0},
            '{FUNC_SPARE,  12345,       1, 1'b0,     0, 1'b0},
            '{FUNC_GPS,        0,   49163, 1'b0,     0, 1'b0},
            '{FUNC_TICK,  -32768,       0, 1'b0,     0, 1'b0}
        };

        step_plan[0] = STEP_RESET;
        step_plan[1] = '0;
        step_plan[2] = 18'd163840;
        step_plan[3] = 18'd1;
        step_plan[4] = '1;
        step_plan[5] = STEP_W'($urandom_range(1, 163840));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 16; i++) begin
            if (i == 5) begin
                // full calibration at the negative rate extreme
                for (int k = 0; k < CAL_LEN; k++) begin
                    b.func       = FUNC_CAL;
                    b.gyro_rate  = -16'sd32768;
                    b.gps_course = ANGLE_W'($urandom);
                    want.heading   = '0;
                    want.ready_res = (k == CAL_LEN - 1);
                    send_beat(b, 1'b1, want);
                end
            end
            b.func         = dir_tbl[i].func;
            b.gyro_rate    = dir_tbl[i].rate[RATE_W-1:0];
            b.gps_course   = dir_tbl[i].course[ANGLE_W-1:0];
            want.heading   = dir_tbl[i].want_hdg[ANGLE_W-1:0];
            want.ready_res = dir_tbl[i].want_rdy;
            send_beat(b, dir_tbl[i].fixed, want);
        end

        // recalibrations in phases 0 and 3, the latter near the positive extreme
        for (int p = 0; p < 6; p++) begin
            if (p > 0) write_step(step_plan[p]);
            if (p == 0) begin
                centre = int'($urandom_range(0, 4000)) - 2000;
                run_phase(1'b1, centre, 0);
            end else if (p == 3) begin
                run_phase(1'b1, 32767, 0);
            end else begin
                run_phase(1'b0, est_bias / CAL_LEN + spread(500), 100);
            end
        end

        in_valid <= 1'b0;
        drain = 0;
        while (heading_due_q.size() != 0 && drain < 5000) begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (heading_due_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", heading_due_q.size()));

        $display("run: %0d beats in (%0d cal, %0d tick, %0d gps, %0d spare), %0d results out",
                 n_cal + n_tick + n_gps + n_spare, n_cal, n_tick, n_gps, n_spare,
                 results_seen);
        $display("run: %0d bias calibrations, %0d step writes, %0d failures",
                 cal_rounds, step_writes, fail_cnt);
        if (fail_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
